[rtl/pols_pkg.sv]
// ============================================================================
// pols_pkg
// Types, codes and character-class helpers of the Pascal outline scanner.
// ============================================================================
package pols_pkg;

    // One input transfer: a source byte and the end-of-document flag
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    // One result transfer
    typedef struct packed {
        logic [1:0]  item_kind;
        logic [7:0]  name_char;
        logic [7:0]  lower_char;
        logic [23:0] name_offset;
        logic [7:0]  name_length;
        logic        run_last;
    } t_out;

    // Result kinds
    localparam logic [1:0] KIND_ROUTINE = 2'd0;
    localparam logic [1:0] KIND_UNIT    = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Scanner modes, one-hot
    typedef enum logic [7:0] {
        M_NORMAL = 8'b0000_0001,
        M_FWAIT  = 8'b0000_0010,
        M_FNAME  = 8'b0000_0100,
        M_USKIP  = 8'b0000_1000,
        M_UNAME  = 8'b0001_0000,
        M_CBRACE = 8'b0010_0000,
        M_CPAREN = 8'b0100_0000,
        M_CLINE  = 8'b1000_0000
    } t_mode;

    // Held character: '(' or '/' waiting for its partner, '*' inside a paren comment
    typedef enum logic [1:0] {
        P_NONE  = 2'd0,
        P_PAREN = 2'd1,
        P_SLASH = 2'd2,
        P_STAR  = 2'd3
    } t_pend;

    // Write strobes from the scanner into the result queue
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    // Keywords, lower case, first letter in the top byte
    localparam int unsigned WIN_LEN = 10;
    localparam logic [87:0] KW_CONSTRUCTOR = "constructor";
    localparam logic [79:0] KW_DESTRUCTOR  = "destructor";
    localparam logic [63:0] KW_FUNCTION    = "function";
    localparam logic [71:0] KW_PROCEDURE   = "procedure";
    localparam logic [31:0] KW_USES        = "uses";

    // Result queue depth
    localparam int unsigned FIFO_DEPTH = 4;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {["A":"Z"]}) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_rname(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == ".") || (c == "_");
    endfunction

    function automatic logic is_uname(input logic [7:0] c);
        return is_alpha(c) || (c == "_");
    endfunction

    function automatic logic is_opener(input logic [7:0] c);
        return c inside {"{", "(", "/"};
    endfunction

endpackage

[rtl/pols_result_fifo.sv]
// ============================================================================
// pols_result_fifo
// Small result queue: takes up to two results per cycle, hands out one while the receiver is ready.
// ============================================================================
module pols_result_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pols_pkg::t_push i_push,
    input  pols_pkg::t_out  i_data0,
    input  pols_pkg::t_out  i_data1,
    output logic          o_room2,
    output logic          o_valid,
    input  logic          i_ready,
    output pols_pkg::t_out  o_data
);
    import pols_pkg::*;

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    t_out             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [PTR_W-1:0] wr_ptr1;
    logic             pop;

    assign pop     = (r_count != '0) && i_ready;
    assign wr_ptr1 = r_wr_ptr + 1'b1;
    assign n_count = r_count + CNT_W'(i_push.first) + CNT_W'(i_push.second)
                     - CNT_W'(pop);

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push.second) begin
            r_mem[wr_ptr1] <= i_data1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push.first) + PTR_W'(i_push.second);
            r_rd_ptr <= r_rd_ptr + PTR_W'(pop);
            r_count  <= n_count;
        end
    end

    assign o_room2 = (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[rtl/pascal_outline_scanner.sv]
// ============================================================================
// pascal_outline_scanner
// Scans Pascal source bytes and reports routine and unit names for an outline.
// ============================================================================
// Input channel (i_in_*): one source byte per transfer, with end_of_text on
// the last byte of a document. Output channel (o_out_*): name bytes of
// routines (with the offset just after the keyword) and of units in a uses
// list, each name closed by an end marker carrying its length; run_last
// flags the last result caused by one input byte.
// Each byte is handled in the cycle it is transferred; its zero, one or two
// results enter a four-entry result queue and are visible in the next cycle.
// Throughput is one byte per cycle while each byte yields at most one result
// and the receiver is ready; a byte yielding two results hands them out one
// after the other through the single output port of the result queue.
// The input is taken whenever the queue has room for two results, so a
// stalled receiver holds the input off once the queue fills; nothing is lost.
// i_cfg_wr_en writes unit_output_enable (reset 1) at once; write it only
// while the block is idle.
// Reset (i_rst_n low, synchronous) empties the queue and puts the scanner in
// normal text mode. The end of a document returns the scanner to that same
// state; unit_output_enable is kept.
// ============================================================================
module pascal_outline_scanner #(
    parameter int MAX_NAME    = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pols_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pols_pkg::t_out o_out_data,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data
);
    import pols_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_NAME);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME - 1);

    // Scanner state
    logic                   r_unit_en;
    t_mode                  r_mode,  n_mode;
    t_mode                  r_ret,   n_ret;
    t_pend                  r_pend,  n_pend;
    logic [7:0]             r_win [WIN_LEN];
    logic [7:0]             n_win [WIN_LEN];
    logic [OFFSET_BITS-1:0] r_pos,   n_pos;
    logic [LEN_W-1:0]       r_len,   n_len;
    logic [OFFSET_BITS-1:0] r_off,   n_off;

    // Step logic
    logic             in_fire;
    logic             room2;
    logic [7:0]       c;
    logic [7:0]       lc;
    logic [7:0]       win_a [WIN_LEN];
    t_mode            mode_a;
    logic             stop;
    logic             norm;
    logic             do_open;
    t_mode            open_ret;
    logic [87:0]      lw;
    logic             kw_rtn;
    logic             kw_uses;
    logic             e1_v;
    logic             e2_v;
    t_out             e1;
    t_out             e2;
    t_out             res0;
    t_out             res1;
    t_push            push;
    logic [31:0]      off32;

    function automatic t_out make_result(input logic [1:0] kind, input logic [7:0] ch,
                                         input logic [23:0] off, input logic [7:0] len);
        t_out r;
        r.item_kind   = kind;
        r.name_char   = ch;
        r.lower_char  = to_lower(ch);
        r.name_offset = off;
        r.name_length = len;
        r.run_last    = 1'b0;
        return r;
    endfunction

    assign in_fire    = i_in_valid && room2;
    assign o_in_ready = room2;
    assign c          = i_in_data.text_byte;
    assign lc         = to_lower(c);
    assign off32      = 32'(r_off);

    // Resolve a held '(' or '/' against the new byte
    always_comb begin
        win_a  = r_win;
        mode_a = r_mode;
        stop   = 1'b0;
        if ((r_mode == M_NORMAL) || (r_mode == M_FWAIT) || (r_mode == M_USKIP)) begin
            if ((r_pend == P_PAREN) || (r_pend == P_SLASH)) begin
                if (((r_pend == P_PAREN) && (c == "*")) ||
                    ((r_pend == P_SLASH) && (c == "/"))) begin
                    stop = 1'b1;
                end else if (r_mode != M_USKIP) begin
                    // held byte becomes ordinary text
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        win_a[i] = r_win[i+1];
                    end
                    win_a[WIN_LEN-1] = (r_pend == P_PAREN) ? 8'("(") : 8'("/");
                    mode_a = M_NORMAL;
                end
            end
        end
    end

    // Keyword match on the lowered window plus the new byte
    always_comb begin
        for (int i = 0; i < WIN_LEN; i++) begin
            lw[87 - 8*i -: 8] = win_a[i];
        end
        lw[7:0] = lc;
        kw_uses = (lw[31:0] == KW_USES);
        kw_rtn  = (lw[87:0] == KW_CONSTRUCTOR) || (lw[79:0] == KW_DESTRUCTOR) ||
                  (lw[63:0] == KW_FUNCTION)    || (lw[71:0] == KW_PROCEDURE);
    end

    // Mode logic for one byte
    always_comb begin
        n_mode   = mode_a;
        n_ret    = r_ret;
        n_pend   = r_pend;
        n_win    = win_a;
        n_pos    = r_pos + 1'b1;
        n_len    = r_len;
        n_off    = r_off;
        norm     = 1'b0;
        do_open  = 1'b0;
        open_ret = M_NORMAL;
        e1_v     = 1'b0;
        e2_v     = 1'b0;
        e1       = make_result(KIND_ROUTINE, c, off32[23:0], 8'd0);
        e2       = make_result(KIND_END, 8'd0, off32[23:0], 8'd0);

        if ((r_mode == M_NORMAL) || (r_mode == M_FWAIT) || (r_mode == M_USKIP)) begin
            n_pend = P_NONE;
        end

        if (stop) begin
            // paren or line comment opens
            n_ret  = r_mode;
            n_mode = (r_pend == P_PAREN) ? M_CPAREN : M_CLINE;
            n_pend = P_NONE;
            n_win  = '{default: '0};
        end else begin
            case (mode_a)
                M_NORMAL: begin
                    norm = 1'b1;
                end
                M_FWAIT: begin
                    if (is_space(c)) begin
                        n_mode = M_FWAIT;
                    end else if (is_opener(c)) begin
                        do_open  = 1'b1;
                        open_ret = M_FWAIT;
                    end else if (!is_digit(c) && is_rname(c)) begin
                        n_len  = LEN_W'(1);
                        e1_v   = 1'b1;
                        n_mode = M_FNAME;
                    end else begin
                        norm = 1'b1;
                    end
                end
                M_FNAME: begin
                    if (is_rname(c)) begin
                        if (r_len < LEN_MAX) begin
                            n_len = r_len + 1'b1;
                            e1_v  = 1'b1;
                        end
                    end else begin
                        e1_v  = 1'b1;
                        e1    = make_result(KIND_END, 8'd0, off32[23:0], 8'(r_len));
                        n_len = '0;
                        norm  = 1'b1;
                    end
                end
                M_USKIP: begin
                    if (is_space(c)) begin
                        n_mode = M_USKIP;
                    end else if (is_opener(c)) begin
                        do_open  = 1'b1;
                        open_ret = M_USKIP;
                    end else if (is_uname(c)) begin
                        n_len  = LEN_W'(1);
                        e1_v   = r_unit_en;
                        e1     = make_result(KIND_UNIT, c, 24'd0, 8'd0);
                        n_mode = M_UNAME;
                    end else if (c == ";") begin
                        n_mode = M_NORMAL;
                    end
                end
                M_UNAME: begin
                    if (is_uname(c)) begin
                        e1 = make_result(KIND_UNIT, c, 24'd0, 8'd0);
                        if (r_len < LEN_MAX) begin
                            n_len = r_len + 1'b1;
                            e1_v  = r_unit_en;
                        end
                    end else begin
                        e1_v   = r_unit_en;
                        e1     = make_result(KIND_END, 8'd0, 24'd0, 8'(r_len));
                        n_len  = '0;
                        n_mode = (c == ";") ? M_NORMAL : M_USKIP;
                    end
                end
                M_CBRACE: begin
                    if (c == "}") begin
                        n_mode = r_ret;
                    end
                end
                M_CLINE: begin
                    if (c == 8'd10) begin
                        n_mode = r_ret;
                    end
                end
                M_CPAREN: begin
                    if ((r_pend == P_STAR) && (c == ")")) begin
                        n_pend = P_NONE;
                        n_mode = r_ret;
                    end else begin
                        n_pend = (c == "*") ? P_STAR : P_NONE;
                    end
                end
                default: begin
                    n_mode = M_NORMAL;
                end
            endcase

            // Normal text, also reached again after a name or a failed name start
            if (norm) begin
                n_mode = M_NORMAL;
                if (is_opener(c)) begin
                    do_open  = 1'b1;
                    open_ret = M_NORMAL;
                end else if (kw_uses) begin
                    n_win  = '{default: '0};
                    n_mode = M_USKIP;
                    n_off  = '0;
                end else if (kw_rtn) begin
                    n_win  = '{default: '0};
                    n_mode = M_FWAIT;
                    n_off  = r_pos + 1'b1;
                end else begin
                    for (int i = 0; i < WIN_LEN - 1; i++) begin
                        n_win[i] = win_a[i+1];
                    end
                    n_win[WIN_LEN-1] = lc;
                end
            end

            // Comment openers
            if (do_open) begin
                if (c == "{") begin
                    n_ret  = open_ret;
                    n_mode = M_CBRACE;
                    n_pend = P_NONE;
                    n_win  = '{default: '0};
                end else if (c == "(") begin
                    n_pend = P_PAREN;
                end else begin
                    n_pend = P_SLASH;
                end
            end
        end

        // End of document: close an open name, then back to reset state
        if (i_in_data.end_of_text) begin
            if (n_mode == M_FNAME) begin
                e2_v = 1'b1;
                e2   = make_result(KIND_END, 8'd0, off32[23:0], 8'(n_len));
            end else if ((n_mode == M_UNAME) && r_unit_en) begin
                e2_v = 1'b1;
                e2   = make_result(KIND_END, 8'd0, 24'd0, 8'(n_len));
            end
            n_mode = M_NORMAL;
            n_ret  = M_NORMAL;
            n_pend = P_NONE;
            n_win  = '{default: '0};
            n_pos  = '0;
            n_len  = '0;
            n_off  = '0;
        end
    end

    // Pack results into queue slots and mark the last one
    always_comb begin
        res0 = e1_v ? e1 : e2;
        res1 = e2;
        if (e1_v && e2_v) begin
            res1.run_last = 1'b1;
        end else begin
            res0.run_last = 1'b1;
        end
        push.first  = in_fire && (e1_v || e2_v);
        push.second = in_fire && e1_v && e2_v;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_NORMAL;
            r_ret  <= M_NORMAL;
            r_pend <= P_NONE;
            r_win  <= '{default: '0};
            r_pos  <= '0;
            r_len  <= '0;
            r_off  <= '0;
        end else if (in_fire) begin
            r_mode <= n_mode;
            r_ret  <= n_ret;
            r_pend <= n_pend;
            r_win  <= n_win;
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_off  <= n_off;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_unit_en <= i_cfg_wr_data;
        end
    end

    pols_result_fifo u_result_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data0 (res0),
        .i_data1 (res1),
        .o_room2 (room2),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
